// File: sv/pgtf_pkg.sv
// Shared types and constants for the palette/grid text to framebuffer unit.
// Holds the input and result beat structs and the action and result codes.
// Depends on nothing; every other file refers to it by scoped names.
package pgtf_pkg;

  localparam int unsigned CfgWidth   = 9;
  localparam int unsigned ColorWidth = 24;

  // Actions carried by an input beat.
  localparam logic [1:0] ACT_PALETTE = 2'd0;
  localparam logic [1:0] ACT_GRID    = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  // Kinds of result beat.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Palette text syntax.
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [2:0] ENTRY_DIGITS = 3'd6;
  localparam logic [2:0] ENTRY_LEN_MAX = 3'd7;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] pixel_index;
  } in_beat_t;

  typedef struct packed {
    logic                  result_kind;
    logic                  draw_ok;
    logic [ColorWidth-1:0] pixel_color;
  } out_beat_t;

endpackage

// File: sv/palette_grid_text_to_framebuffer_unit.sv
// Top level of the palette/grid text to framebuffer unit.
// Parses palette and grid text, stages pixels, reads pixels, swaps the shown bank.
// Depends on pgtf_pkg for the beat structs, action codes and text constants.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+---------------------------
//   input     | in        | in_valid_i / in_stall_o | pgtf_pkg::in_beat_t
//   result    | out       | out_valid_o / out_stall_i | pgtf_pkg::out_beat_t
//   config    | in        | cfg_we_i               | cfg_wdata_i (pixel_count)
//
// One input beat is accepted every cycle while input is not stalled, and it
// updates the command state as it is accepted. The frame memory read data is
// registered beside the result stage; each result passes through the result
// stage and then the result register. The frame memory has one write and one
// read port. After reset the unit sweeps all 2**(AW+1) frame words (512 with
// the default size) to black, one word a cycle, and stalls input meanwhile.
// A stalled result holds in the result register while the stage behind it
// keeps one more result, so outside the sweep input only stalls on both full.
module palette_grid_text_to_framebuffer_unit #(
  parameter int unsigned MAX_PIXELS   = 256,
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pgtf_pkg::CfgWidth-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pgtf_pkg::in_beat_t                 in_beat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pgtf_pkg::out_beat_t                out_beat_o
);

  // Address width of one bank, grid counter width and a common compare width.
  localparam int unsigned AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned GS_W  = $clog2(MAX_PIXELS + 2);
  localparam int unsigned CW    = (GS_W > pgtf_pkg::CfgWidth) ? GS_W : pgtf_pkg::CfgWidth;
  localparam int unsigned DEPTH = 2 ** (AW + 1);
  localparam int unsigned PW    = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int unsigned CLR   = pgtf_pkg::ColorWidth;

  // Configuration and command state.
  logic [pgtf_pkg::CfgWidth-1:0] pixel_count_q;
  logic                          shown_bank_q, shown_bank_d;
  logic [4:0]                    pal_used_q, pal_used_d;
  logic [CLR-1:0]                entry_value_q, entry_value_d;
  logic [2:0]                    entry_len_q, entry_len_d;
  logic                          entry_inv_q, entry_inv_d;
  logic [GS_W-1:0]               grid_seen_q, grid_seen_d;
  logic                          in_grid_q, in_grid_d;
  logic                          cmd_failed_q, cmd_failed_d;
  logic [CLR-1:0]                pal_q [PALETTE_SIZE];

  // Frame memory and its clearing sweep.
  logic [CLR-1:0] frame_mem [DEPTH];
  logic [AW:0]    clr_addr_q;
  logic           clearing_q;
  logic [CLR-1:0] rdata_q;

  // Result stage behind the memory read and the result register.
  logic s1_valid_q, s1_kind_q, s1_ok_q, s1_inrange_q;
  logic out_valid_q;
  pgtf_pkg::out_beat_t out_beat_q;

  // Decoded step signals.
  logic           in_acc, advance;
  logic [CW-1:0]  eff_count, gs_ext, idx_ext;
  logic           hex_ok;
  logic [3:0]     hex_val;
  logic           entry_empty, entry_good, entry_bad;
  logic           close_now;
  logic [4:0]     used_after;
  logic           failed_after, grid_bad, end_ok;
  logic [CLR-1:0] pal_color;
  logic           pal_we, pix_we, rd_en, res_valid, res_kind, res_ok, res_inrange;
  logic           mem_we;
  logic [AW:0]    mem_waddr;
  logic [CLR-1:0] mem_wdata;

  // Hex digit decode: returns a valid flag above the 4-bit digit value.
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= "0" && ch <= "9") begin
      r = {1'b1, 4'(ch - "0")};
    end else if (ch >= "a" && ch <= "f") begin
      r = {1'b1, 4'(ch - "a") + pgtf_pkg::HEX_ALPHA_BASE};
    end else if (ch >= "A" && ch <= "F") begin
      r = {1'b1, 4'(ch - "A") + pgtf_pkg::HEX_ALPHA_BASE};
    end
    return r;
  endfunction

  // The result register moves when it is empty or being taken; the stage
  // behind it can then move too, and input waits on a full pair or the sweep.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = clearing_q || (s1_valid_q && !advance);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign eff_count = (CW'(pixel_count_q) < CW'(MAX_PIXELS)) ? CW'(pixel_count_q)
                                                            : CW'(MAX_PIXELS);
  assign gs_ext    = CW'(grid_seen_q);
  assign idx_ext   = CW'(in_beat_i.pixel_index);
  assign {hex_ok, hex_val} = hex_decode(in_beat_i.char_code);

  // Closing the open palette entry: empty, well formed, or a failure.
  assign entry_empty = (entry_len_q == 3'd0) && !entry_inv_q;
  assign entry_good  = !entry_empty && (entry_len_q == pgtf_pkg::ENTRY_DIGITS) &&
                       !entry_inv_q && (pal_used_q < 5'(PALETTE_SIZE));
  assign entry_bad   = !entry_empty && !entry_good;

  // The first grid character and the end beat close the palette implicitly,
  // where an empty trailing entry is tolerated.
  assign close_now    = !in_grid_q;
  assign used_after   = pal_used_q + 5'(close_now && entry_good);
  assign failed_after = cmd_failed_q || (close_now && entry_bad);

  // A grid digit may select the entry being closed in this same cycle.
  always_comb begin
    if (close_now && entry_good && ({1'b0, hex_val} == pal_used_q)) begin
      pal_color = entry_value_q;
    end else begin
      pal_color = pal_q[hex_val[PW-1:0]];
    end
  end

  assign grid_bad = !hex_ok || ({1'b0, hex_val} >= used_after) || (gs_ext >= eff_count);
  assign end_ok   = !failed_after && (used_after != 5'd0) && (gs_ext == eff_count);

  always_comb begin
    shown_bank_d  = shown_bank_q;
    pal_used_d    = pal_used_q;
    entry_value_d = entry_value_q;
    entry_len_d   = entry_len_q;
    entry_inv_d   = entry_inv_q;
    grid_seen_d   = grid_seen_q;
    in_grid_d     = in_grid_q;
    cmd_failed_d  = cmd_failed_q;
    pal_we        = 1'b0;
    pix_we        = 1'b0;
    rd_en         = 1'b0;
    res_valid     = 1'b0;
    res_kind      = pgtf_pkg::KIND_STATUS;
    res_ok        = 1'b0;
    res_inrange   = 1'b0;
    if (in_acc) begin
      case (in_beat_i.action)
        pgtf_pkg::ACT_PALETTE: begin
          if (in_grid_q) begin
            cmd_failed_d = 1'b1;
          end else if (in_beat_i.char_code == pgtf_pkg::CHAR_COMMA) begin
            // An explicit comma does not tolerate an empty entry.
            cmd_failed_d  = cmd_failed_q || entry_bad || entry_empty;
            pal_we        = entry_good;
            pal_used_d    = pal_used_q + 5'(entry_good);
            entry_value_d = '0;
            entry_len_d   = 3'd0;
            entry_inv_d   = 1'b0;
          end else begin
            if (hex_ok) begin
              entry_value_d = {entry_value_q[CLR-5:0], hex_val};
            end else begin
              entry_inv_d = 1'b1;
            end
            if (entry_len_q < pgtf_pkg::ENTRY_LEN_MAX) begin
              entry_len_d = entry_len_q + 3'd1;
            end
          end
        end
        pgtf_pkg::ACT_GRID: begin
          if (close_now) begin
            pal_we        = entry_good;
            pal_used_d    = used_after;
            entry_value_d = '0;
            entry_len_d   = 3'd0;
            entry_inv_d   = 1'b0;
            in_grid_d     = 1'b1;
          end
          cmd_failed_d = failed_after || grid_bad;
          pix_we       = !grid_bad && !failed_after;
          if (grid_seen_q <= GS_W'(MAX_PIXELS)) begin
            grid_seen_d = grid_seen_q + GS_W'(1);
          end
        end
        pgtf_pkg::ACT_END: begin
          if (end_ok) begin
            shown_bank_d = !shown_bank_q;
          end
          pal_used_d    = 5'd0;
          entry_value_d = '0;
          entry_len_d   = 3'd0;
          entry_inv_d   = 1'b0;
          grid_seen_d   = '0;
          in_grid_d     = 1'b0;
          cmd_failed_d  = 1'b0;
          res_valid     = 1'b1;
          res_kind      = pgtf_pkg::KIND_STATUS;
          res_ok        = end_ok;
        end
        pgtf_pkg::ACT_READ: begin
          rd_en       = 1'b1;
          res_valid   = 1'b1;
          res_kind    = pgtf_pkg::KIND_PIXEL;
          res_inrange = idx_ext < eff_count;
        end
        default: begin
          cmd_failed_d = cmd_failed_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= pgtf_pkg::CfgWidth'(64);
      shown_bank_q  <= 1'b0;
      pal_used_q    <= 5'd0;
      entry_value_q <= '0;
      entry_len_q   <= 3'd0;
      entry_inv_q   <= 1'b0;
      grid_seen_q   <= '0;
      in_grid_q     <= 1'b0;
      cmd_failed_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pixel_count_q <= cfg_wdata_i;
      end
      shown_bank_q  <= shown_bank_d;
      pal_used_q    <= pal_used_d;
      entry_value_q <= entry_value_d;
      entry_len_q   <= entry_len_d;
      entry_inv_q   <= entry_inv_d;
      grid_seen_q   <= grid_seen_d;
      in_grid_q     <= in_grid_d;
      cmd_failed_q  <= cmd_failed_d;
    end
  end

  // Palette entries are only read after being written in the same command.
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_q[pal_used_q[PW-1:0]] <= entry_value_q;
    end
  end

  // Clearing sweep after reset: writes black into every frame word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + (AW + 1)'(1);
      if (clr_addr_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Grid pixels go to the hidden bank; reads come from the shown bank.
  assign mem_we    = clearing_q || pix_we;
  assign mem_waddr = clearing_q ? clr_addr_q : {!shown_bank_q, grid_seen_q[AW-1:0]};
  assign mem_wdata = clearing_q ? '0 : pal_color;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= frame_mem[{shown_bank_q, idx_ext[AW-1:0]}];
    end
  end

  // Result stage, then the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= res_valid;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q    <= res_kind;
      s1_ok_q      <= res_ok;
      s1_inrange_q <= res_inrange;
    end
    if (advance && s1_valid_q) begin
      out_beat_q.result_kind <= s1_kind_q;
      out_beat_q.draw_ok     <= s1_ok_q;
      out_beat_q.pixel_color <= (s1_kind_q == pgtf_pkg::KIND_PIXEL && s1_inrange_q) ?
                                rdata_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // A status result never carries a color, and a pixel result never an ok.
  a_status_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_beat_q.result_kind == pgtf_pkg::KIND_STATUS)
      |-> (out_beat_q.pixel_color == '0))
    else $error("status result carries a color");

  a_pixel_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_beat_q.result_kind == pgtf_pkg::KIND_PIXEL) |-> !out_beat_q.draw_ok)
    else $error("pixel result carries draw_ok");

  // A successful end swaps the banks; any end leaves a fresh command.
  a_swap_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.action == pgtf_pkg::ACT_END) && end_ok
      |=> (shown_bank_q != $past(shown_bank_q)))
    else $error("bank not swapped after a successful command");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.action == pgtf_pkg::ACT_END)
      |=> (pal_used_q == 5'd0) && !in_grid_q && (grid_seen_q == '0) && !cmd_failed_q)
    else $error("command state not cleared by end beat");

  a_palette_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_used_q <= 5'(PALETTE_SIZE))
    else $error("palette entry count beyond palette size");

endmodule
